@@ rtl/core/iee_pkg.sv @@
// ============================================================================
// iee_pkg : shared constants for the infix expression evaluator
// Character codes, operator and error encodings, default widths.
// ============================================================================
`default_nettype none

package iee_pkg;

    // default widths of the fixed point value
    localparam int VALUE_WIDTH_DEFAULT   = 48;
    localparam int FRACTION_BITS_DEFAULT = 16;

    // radix of the decimal numbers in the expression
    localparam int DIGIT_BASE = 10;

    // ascii codes of the accepted symbols
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    // error codes, first one seen in an expression is kept
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_SYMBOL   = 2'd1;
    localparam logic [1:0] ERR_DIV_ZERO = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    // pending multiply or divide
    localparam logic [1:0] MD_NONE = 2'd0;
    localparam logic [1:0] MD_MUL  = 2'd1;
    localparam logic [1:0] MD_DIV  = 2'd2;

    // pending sign of the current term
    localparam logic SIGN_PLUS  = 1'b0;
    localparam logic SIGN_MINUS = 1'b1;

    // class of the character being processed
    localparam logic [1:0] OP_DIGIT  = 2'd0;
    localparam logic [1:0] OP_MULDIV = 2'd1;
    localparam logic [1:0] OP_ADDSUB = 2'd2;
    localparam logic [1:0] OP_BAD    = 2'd3;

endpackage

`default_nettype wire

@@ rtl/core/infix_expression_evaluator_top.sv @@
// ============================================================================
// infix_expression_evaluator_top : character stream expression evaluator
// Evaluates + - * / over decimal numbers with precedence, in signed fixed
// point, and returns the value and an error code on the last character.
// ============================================================================
//
// channel  dir  handshake             payload
// s_*      in   s_tvalid / s_tready   tdata = character, tlast = last
// m_*      out  m_tvalid / m_tready   tdata = value, error
//
// a bad symbol only records its error; a digit is multiplied by ten and,
// unless that saturates, added; * or / folds the pending operation and + or -
// also adds the term into the sum; a pending multiply runs radix-2 shift-add,
// a pending divide a restoring divide (one quotient bit per cycle, none by zero)
// the last character adds a fold, a sum update and the result load
// reset clears the control and accumulator registers; a stalled result holds
// in the output register while the next expression is already taken in
`default_nettype none

module infix_expression_evaluator_top #(
    parameter int VALUE_WIDTH   = iee_pkg::VALUE_WIDTH_DEFAULT,
    parameter int FRACTION_BITS = iee_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // request in
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [7:0]                             s_tdata,  // [7:0] character
    input  wire logic                                   s_tlast,  // last
    // result out
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [((VALUE_WIDTH + 2 + 7) / 8) * 8 - 1:0] m_tdata  // value, error
);

    localparam int W      = VALUE_WIDTH;
    localparam int F      = FRACTION_BITS;
    localparam int OUT_W  = ((W + 2 + 7) / 8) * 8;
    localparam int QUOT_W = W + F;
    localparam int MAG_W  = (2 * W > QUOT_W) ? 2 * W : QUOT_W;
    localparam int SUM_W  = ((W > F + 4) ? W : F + 4) + 1;
    localparam int CNT_W  = $clog2(QUOT_W);

    localparam logic [W-1:0] VMAX_C     = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN_C     = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] VMAX_DIV10 = VMAX_C / W'(iee_pkg::DIGIT_BASE);
    localparam logic [MAG_W-1:0] MAG_POS_LIM = MAG_W'(VMAX_C);
    localparam logic [MAG_W-1:0] MAG_NEG_LIM = MAG_W'(VMIN_C);
    localparam logic [SUM_W-1:0] DIG_LIM     = SUM_W'(VMAX_C);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIG_A = 4'd1;
    localparam logic [3:0] S_DIG_B = 4'd2;
    localparam logic [3:0] S_FOLD  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_FIN   = 4'd6;
    localparam logic [3:0] S_CLOSE = 4'd7;
    localparam logic [3:0] S_NEXT  = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    // control and accumulator registers
    logic [3:0]       state_reg,     state_next;
    logic             last_reg,      last_next;
    logic             final_reg,     final_next;
    logic [1:0]       op_reg,        op_next;
    logic [W-1:0]     number_reg,    number_next;
    logic [W-1:0]     term_reg,      term_next;
    logic [W-1:0]     sum_reg,       sum_next;
    logic [1:0]       muldiv_reg,    muldiv_next;
    logic             sign_reg,      sign_next;
    logic [1:0]       err_reg,       err_next;
    logic [CNT_W-1:0] cnt_reg,       cnt_next;
    logic             out_valid_reg, out_valid_next;

    // datapath registers
    logic [7:0]       char_reg,      char_next;
    logic             neg_reg,       neg_next;
    logic [W-1:0]     mcand_reg,     mcand_next;
    logic [2*W:0]     prod_reg,      prod_next;
    logic [QUOT_W-1:0] quot_reg,     quot_next;
    logic [W-1:0]     rem_reg,       rem_next;
    logic [W-1:0]     out_value_reg, out_value_next;
    logic [1:0]       out_error_reg, out_error_next;

    // combinational helpers
    logic [1:0]       in_op;
    logic [W-1:0]     term_mag;
    logic [W:0]       mul_add;
    logic [W-1:0]     div_trial;
    logic             div_take;
    logic [MAG_W-1:0] fold_mag;
    logic [W-1:0]     fold_val;
    logic             fold_over;
    logic [SUM_W-1:0] dig_sum;
    logic [W:0]       close_sum;
    logic             out_free;

    // keep the first error of the expression
    function automatic logic [1:0] first_err(input logic [1:0] cur, input logic [1:0] code);
        first_err = (cur == iee_pkg::ERR_NONE) ? code : cur;
    endfunction

    // handshake ports
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_error_reg, out_value_reg});
    assign out_free = !out_valid_reg || m_tready;

    // class of the incoming character
    always_comb
    begin
        priority if (s_tdata >= iee_pkg::CHAR_ZERO && s_tdata <= iee_pkg::CHAR_NINE)
        begin
            in_op = iee_pkg::OP_DIGIT;
        end
        else if (s_tdata == iee_pkg::CHAR_STAR || s_tdata == iee_pkg::CHAR_SLASH)
        begin
            in_op = iee_pkg::OP_MULDIV;
        end
        else if (s_tdata == iee_pkg::CHAR_PLUS || s_tdata == iee_pkg::CHAR_MINUS)
        begin
            in_op = iee_pkg::OP_ADDSUB;
        end
        else
        begin
            in_op = iee_pkg::OP_BAD;
        end
    end

    // magnitude of the term, one shift-add step, one restoring divide step
    assign term_mag  = term_reg[W-1] ? (W'(0) - term_reg) : term_reg;
    assign mul_add   = prod_reg[2*W:W] + (prod_reg[0] ? (W+1)'(mcand_reg) : (W+1)'(0));
    assign div_trial = {rem_reg[W-2:0], quot_reg[QUOT_W-1]};
    assign div_take  = (div_trial >= number_reg);

    // saturation of a finished product or quotient
    always_comb
    begin
        if (muldiv_reg == iee_pkg::MD_DIV)
        begin
            fold_mag = MAG_W'(quot_reg);
        end
        else
        begin
            fold_mag = MAG_W'(prod_reg[2*W-1:0] >> F);
        end
        if (neg_reg)
        begin
            fold_over = (fold_mag > MAG_NEG_LIM);
            fold_val  = fold_over ? VMIN_C : (W'(0) - fold_mag[W-1:0]);
        end
        else
        begin
            fold_over = (fold_mag > MAG_POS_LIM);
            fold_val  = fold_over ? VMAX_C : fold_mag[W-1:0];
        end
    end

    // digit add and running sum, both one wide add wider than the word
    assign dig_sum   = SUM_W'(number_reg) + (SUM_W'(char_reg[3:0]) << F);
    assign close_sum = (sign_reg == iee_pkg::SIGN_MINUS)
                     ? ({sum_reg[W-1], sum_reg} - {term_reg[W-1], term_reg})
                     : ({sum_reg[W-1], sum_reg} + {term_reg[W-1], term_reg});

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        last_next      = last_reg;
        final_next     = final_reg;
        op_next        = op_reg;
        number_next    = number_reg;
        term_next      = term_reg;
        sum_next       = sum_reg;
        muldiv_next    = muldiv_reg;
        sign_next      = sign_reg;
        err_next       = err_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        char_next      = char_reg;
        neg_next       = neg_reg;
        mcand_next     = mcand_reg;
        prod_next      = prod_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        out_value_next = out_value_reg;
        out_error_next = out_error_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    char_next = s_tdata;
                    last_next = s_tlast;
                    op_next   = in_op;
                    unique case (in_op)
                        iee_pkg::OP_DIGIT:  state_next = S_DIG_A;
                        iee_pkg::OP_MULDIV: state_next = S_FOLD;
                        iee_pkg::OP_ADDSUB: state_next = S_FOLD;
                        default:
                        begin
                            err_next   = first_err(err_reg, iee_pkg::ERR_SYMBOL);
                            state_next = S_NEXT;
                        end
                    endcase
                end
            end

            // number times ten, saturating
            S_DIG_A:
            begin
                if (number_reg > VMAX_DIV10)
                begin
                    number_next = VMAX_C;
                    err_next    = first_err(err_reg, iee_pkg::ERR_OVERFLOW);
                    state_next  = S_NEXT;
                end
                else
                begin
                    number_next = (number_reg << 3) + (number_reg << 1);
                    state_next  = S_DIG_B;
                end
            end

            // add the digit, saturating
            S_DIG_B:
            begin
                if (dig_sum > DIG_LIM)
                begin
                    number_next = VMAX_C;
                    err_next    = first_err(err_reg, iee_pkg::ERR_OVERFLOW);
                end
                else
                begin
                    number_next = dig_sum[W-1:0];
                end
                state_next = S_NEXT;
            end

            // apply the pending multiply or divide to the number
            S_FOLD:
            begin
                neg_next = term_reg[W-1];
                unique case (muldiv_reg)
                    iee_pkg::MD_MUL:
                    begin
                        mcand_next = term_mag;
                        prod_next  = (2*W+1)'(number_reg);
                        cnt_next   = CNT_W'(W - 1);
                        state_next = S_MUL;
                    end
                    iee_pkg::MD_DIV:
                    begin
                        if (number_reg == W'(0))
                        begin
                            err_next    = first_err(err_reg, iee_pkg::ERR_DIV_ZERO);
                            term_next   = term_reg[W-1] ? VMIN_C : VMAX_C;
                            number_next = W'(0);
                            muldiv_next = iee_pkg::MD_NONE;
                            state_next  = S_CLOSE;
                            if (!final_reg && op_reg == iee_pkg::OP_MULDIV)
                            begin
                                muldiv_next = (char_reg == iee_pkg::CHAR_STAR)
                                            ? iee_pkg::MD_MUL : iee_pkg::MD_DIV;
                                state_next  = S_NEXT;
                            end
                        end
                        else
                        begin
                            quot_next  = QUOT_W'(term_mag) << F;
                            rem_next   = W'(0);
                            cnt_next   = CNT_W'(QUOT_W - 1);
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                        term_next   = number_reg;
                        number_next = W'(0);
                        muldiv_next = iee_pkg::MD_NONE;
                        state_next  = S_CLOSE;
                        if (!final_reg && op_reg == iee_pkg::OP_MULDIV)
                        begin
                            muldiv_next = (char_reg == iee_pkg::CHAR_STAR)
                                        ? iee_pkg::MD_MUL : iee_pkg::MD_DIV;
                            state_next  = S_NEXT;
                        end
                    end
                endcase
            end

            // shift-add multiply, one multiplier bit per cycle
            S_MUL:
            begin
                prod_next = {1'b0, mul_add, prod_reg[W-1:1]};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(0))
                begin
                    state_next = S_FIN;
                end
            end

            // restoring divide, one quotient bit per cycle
            S_DIV:
            begin
                rem_next  = div_take ? (div_trial - number_reg) : div_trial;
                quot_next = {quot_reg[QUOT_W-2:0], div_take};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(0))
                begin
                    state_next = S_FIN;
                end
            end

            // signed, saturated term from the magnitude
            S_FIN:
            begin
                term_next   = fold_val;
                number_next = W'(0);
                muldiv_next = iee_pkg::MD_NONE;
                if (fold_over)
                begin
                    err_next = first_err(err_reg, iee_pkg::ERR_OVERFLOW);
                end
                state_next = S_CLOSE;
                if (!final_reg && op_reg == iee_pkg::OP_MULDIV)
                begin
                    muldiv_next = (char_reg == iee_pkg::CHAR_STAR)
                                ? iee_pkg::MD_MUL : iee_pkg::MD_DIV;
                    state_next  = S_NEXT;
                end
            end

            // add or subtract the term into the running sum
            S_CLOSE:
            begin
                if (close_sum[W] != close_sum[W-1])
                begin
                    sum_next = close_sum[W] ? VMIN_C : VMAX_C;
                    err_next = first_err(err_reg, iee_pkg::ERR_OVERFLOW);
                end
                else
                begin
                    sum_next = close_sum[W-1:0];
                end
                term_next = W'(0);
                if (!final_reg && op_reg == iee_pkg::OP_ADDSUB)
                begin
                    sign_next = (char_reg == iee_pkg::CHAR_MINUS)
                              ? iee_pkg::SIGN_MINUS : iee_pkg::SIGN_PLUS;
                end
                state_next = S_NEXT;
            end

            // end of a character: idle, final fold or result
            S_NEXT:
            begin
                priority if (final_reg)
                begin
                    state_next = S_EMIT;
                end
                else if (last_reg)
                begin
                    final_next = 1'b1;
                    state_next = S_FOLD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // load the result and clear for the next expression
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = sum_reg;
                    out_error_next = err_reg;
                    number_next    = W'(0);
                    term_next      = W'(0);
                    sum_next       = W'(0);
                    muldiv_next    = iee_pkg::MD_NONE;
                    sign_next      = iee_pkg::SIGN_PLUS;
                    err_next       = iee_pkg::ERR_NONE;
                    final_next     = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and accumulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_reg      <= 1'b0;
            final_reg     <= 1'b0;
            op_reg        <= iee_pkg::OP_DIGIT;
            number_reg    <= '0;
            term_reg      <= '0;
            sum_reg       <= '0;
            muldiv_reg    <= iee_pkg::MD_NONE;
            sign_reg      <= iee_pkg::SIGN_PLUS;
            err_reg       <= iee_pkg::ERR_NONE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            final_reg     <= final_next;
            op_reg        <= op_next;
            number_reg    <= number_next;
            term_reg      <= term_next;
            sum_reg       <= sum_next;
            muldiv_reg    <= muldiv_next;
            sign_reg      <= sign_next;
            err_reg       <= err_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        neg_reg       <= neg_next;
        mcand_reg     <= mcand_next;
        prod_reg      <= prod_next;
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        out_value_reg <= out_value_next;
        out_error_reg <= out_error_next;
    end

    // a taken character always starts work
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg != S_IDLE)
        else $error("accepted character left the sequencer idle");

    // the divider never runs on a zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> number_reg != '0 && muldiv_reg == iee_pkg::MD_DIV)
        else $error("divide running without a nonzero divisor");

    // the multiplier runs only for a pending multiply
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL |-> muldiv_reg == iee_pkg::MD_MUL)
        else $error("multiply running without a pending multiply");

    // loading a result clears the expression state
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && out_free
        |=> m_tvalid && sum_reg == '0 && err_reg == iee_pkg::ERR_NONE && !final_reg)
        else $error("result load did not clear the expression state");

endmodule

`default_nettype wire
